// ----- rtl/core/icte_pkg.sv -----
// shared types and constants for the irc color text encoder
`default_nettype none

package icte_pkg;

    // byte values of the encoded stream
    localparam logic [7:0] C_CTRL_COLOR = 8'h03;
    localparam logic [7:0] C_CH_ZERO    = 8'h30;
    localparam logic [7:0] C_CH_NINE    = 8'h39;
    localparam logic [7:0] C_CH_SPACE   = 8'h20;
    localparam logic [7:0] C_CH_COMMA   = 8'h2c;
    localparam logic [7:0] C_CH_NEWLINE = 8'h0a;

    // largest palette index that is written as itself
    localparam logic [7:0] C_MAX_INDEX  = 8'd99;

    // byte slots of one formatted cell and of one whole frame
    localparam int C_CELL_SLOTS  = 7;
    localparam int C_FRAME_SLOTS = 2 * C_CELL_SLOTS + 1;

    // input request
    typedef struct packed {
        logic [15:0] char_code;
        logic [7:0]  fg_index;
        logic [7:0]  bg_index;
        logic        end_of_row;
    } t_cell_in;

    // output request
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_byte_out;

    // colors of the last emitted cell of the row
    typedef struct packed {
        logic       known;
        logic [7:0] fg;
        logic [7:0] bg;
    } t_color_state;

    // formatted cell: fixed slots with enables
    // slot order: ctrl, fg tens, fg ones, comma, bg tens, bg ones, char
    typedef struct packed {
        logic [C_CELL_SLOTS-1:0]      en;
        logic [C_CELL_SLOTS-1:0][7:0] data;
    } t_cell_slots;

endpackage

`default_nettype wire

// ----- rtl/core/irc_color_text_encoder.sv -----
// Encodes character cells into an IRC color-code byte stream. A cell request
// is taken into an input register; from there one pass of logic formats the
// held-back cell (with this cell's character as lookahead) and, at the end of
// a row, this cell and a newline, into a frame of up to 15 bytes. The frame
// register sends one byte per cycle while i_stall is low, lowest slot first,
// with last set on the final byte of the request. A request that makes no
// bytes puts nothing on the output. The next request is formatted in the same
// cycle in which the previous frame's final byte is taken, so the byte-wide
// output port sets the sustained rate. A cell that is not the last of its row
// stays held until the next request arrives.
`default_nettype none

module irc_color_text_encoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire icte_pkg::t_cell_in  i_data,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output icte_pkg::t_byte_out      o_data
);

    localparam int NS = icte_pkg::C_FRAME_SLOTS;
    localparam int CS = icte_pkg::C_CELL_SLOTS;

    // input register
    logic               r_in_valid, n_in_valid;
    icte_pkg::t_cell_in r_in, n_in;

    // held-back cell and row color memory
    logic        r_pend_valid, n_pend_valid;
    logic [15:0] r_pend_char, n_pend_char;
    logic [7:0]  r_pend_fg, n_pend_fg;
    logic [7:0]  r_pend_bg, n_pend_bg;
    icte_pkg::t_color_state r_color, n_color;

    // frame register
    logic [NS-1:0]      r_mask, n_mask;
    logic [NS-1:0][7:0] r_bytes, n_bytes;

    logic                   in_accept;
    logic                   out_accept;
    logic                   frame_free;
    logic                   load;
    logic                   cur_digit;
    logic [NS-1:0]          low_bit;
    logic [7:0]             sel_byte;
    icte_pkg::t_color_state prior_b;
    icte_pkg::t_cell_slots  slots_a;
    icte_pkg::t_cell_slots  slots_b;

    // handshake
    assign out_accept = o_valid && !i_stall;
    assign frame_free = (r_mask == '0) || (out_accept && o_data.last);
    assign load       = r_in_valid && frame_free;
    assign o_stall    = r_in_valid && !frame_free;
    assign in_accept  = i_valid && !o_stall;

    // lookahead digit test on the full character
    assign cur_digit = (r_in.char_code >= {8'd0, icte_pkg::C_CH_ZERO}) &&
                       (r_in.char_code <= {8'd0, icte_pkg::C_CH_NINE});

    // held cell sees the current row colors
    icte_cell_fmt u_fmt_a (
        .i_char       (r_pend_char),
        .i_fg         (r_pend_fg),
        .i_bg         (r_pend_bg),
        .i_next_digit (cur_digit),
        .i_prior      (r_color),
        .o_slots      (slots_a)
    );

    // last cell of the row follows the held cell's colors
    always_comb begin
        if (r_pend_valid) begin
            prior_b = '{known: 1'b1, fg: r_pend_fg, bg: r_pend_bg};
        end else begin
            prior_b = r_color;
        end
    end

    icte_cell_fmt u_fmt_b (
        .i_char       (r_in.char_code),
        .i_fg         (r_in.fg_index),
        .i_bg         (r_in.bg_index),
        .i_next_digit (1'b0),
        .i_prior      (prior_b),
        .o_slots      (slots_b)
    );

    // lowest pending slot goes out first
    assign low_bit = r_mask & (~r_mask + NS'(1));

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NS; i++) begin
            if (low_bit[i]) begin
                sel_byte = sel_byte | r_bytes[i];
            end
        end
    end

    assign o_valid         = (r_mask != '0);
    assign o_data.out_byte = sel_byte;
    assign o_data.last     = ((r_mask & ~low_bit) == '0);

    // input register next state
    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (in_accept) begin
            n_in_valid = 1'b1;
            n_in       = i_data;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    // frame next state
    always_comb begin
        n_mask  = r_mask;
        n_bytes = r_bytes;
        if (load) begin
            n_mask  = {r_in.end_of_row,
                       slots_b.en & {CS{r_in.end_of_row}},
                       slots_a.en & {CS{r_pend_valid}}};
            n_bytes = {icte_pkg::C_CH_NEWLINE, slots_b.data, slots_a.data};
        end else if (out_accept) begin
            n_mask = r_mask & ~low_bit;
        end
    end

    // held cell and color memory next state
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_char  = r_pend_char;
        n_pend_fg    = r_pend_fg;
        n_pend_bg    = r_pend_bg;
        n_color      = r_color;
        if (load) begin
            if (r_in.end_of_row) begin
                n_pend_valid = 1'b0;
                n_color      = '0;
            end else begin
                n_pend_valid = 1'b1;
                n_pend_char  = r_in.char_code;
                n_pend_fg    = r_in.fg_index;
                n_pend_bg    = r_in.bg_index;
                if (r_pend_valid) begin
                    n_color = '{known: 1'b1, fg: r_pend_fg, bg: r_pend_bg};
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_mask       <= '0;
            r_pend_valid <= 1'b0;
            r_pend_char  <= '0;
            r_pend_fg    <= '0;
            r_pend_bg    <= '0;
            r_color      <= '0;
        end else begin
            r_in_valid   <= n_in_valid;
            r_mask       <= n_mask;
            r_pend_valid <= n_pend_valid;
            r_pend_char  <= n_pend_char;
            r_pend_fg    <= n_pend_fg;
            r_pend_bg    <= n_pend_bg;
            r_color      <= n_color;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_bytes <= n_bytes;
    end

`ifndef SYNTH
    // a row end always produces at least its newline
    a_row_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in.end_of_row |=> o_valid)
        else $error("row end request produced no output");

    // a row end leaves nothing held back
    a_row_end_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in.end_of_row |=> !r_pend_valid && !r_color.known)
        else $error("row end left a held cell or colors");

    // a mid-row cell is held back
    a_mid_row_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && !r_in.end_of_row |=> r_pend_valid)
        else $error("mid-row cell was not held");

    // a waiting input request keeps its contents
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !load |=> r_in_valid && $stable(r_in))
        else $error("waiting input request changed");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/icte_cell_fmt.sv -----
// formats one cell into its color code and character byte slots
`default_nettype none

module icte_cell_fmt (
    input  wire logic [15:0]             i_char,
    input  wire logic [7:0]              i_fg,
    input  wire logic [7:0]              i_bg,
    input  wire logic                    i_next_digit,
    input  wire icte_pkg::t_color_state  i_prior,
    output icte_pkg::t_cell_slots        o_slots
);

    logic       new_fg;
    logic       new_bg;
    logic       fg_two;
    logic [6:0] fg_val;
    logic [6:0] bg_val;
    logic [14:0] fg_prod;
    logic [14:0] bg_prod;
    logic [3:0] fg_tens;
    logic [3:0] bg_tens;
    logic [3:0] fg_ones;
    logic [3:0] bg_ones;
    logic [7:0] ch_byte;

    // change detection on raw indices
    assign new_fg = !i_prior.known || (i_fg != i_prior.fg);
    assign new_bg = !i_prior.known || (i_bg != i_prior.bg);
    assign fg_two = !new_bg && i_next_digit;

    // clamp out-of-range indices to zero
    assign fg_val = (i_fg > icte_pkg::C_MAX_INDEX) ? 7'd0 : i_fg[6:0];
    assign bg_val = (i_bg > icte_pkg::C_MAX_INDEX) ? 7'd0 : i_bg[6:0];

    // tens digit by reciprocal multiply, exact below 160
    assign fg_prod = {8'd0, fg_val} * 15'd205;
    assign bg_prod = {8'd0, bg_val} * 15'd205;
    assign fg_tens = fg_prod[14:11];
    assign bg_tens = bg_prod[14:11];
    assign fg_ones = 4'(fg_val - ({3'd0, fg_tens} * 7'd10));
    assign bg_ones = 4'(bg_val - ({3'd0, bg_tens} * 7'd10));

    // control characters go out as space
    assign ch_byte = (i_char < {8'd0, icte_pkg::C_CH_SPACE}) ? icte_pkg::C_CH_SPACE
                                                             : i_char[7:0];

    // slot contents
    always_comb begin
        o_slots.data[0] = icte_pkg::C_CTRL_COLOR;
        o_slots.data[1] = icte_pkg::C_CH_ZERO + {4'd0, fg_tens};
        o_slots.data[2] = icte_pkg::C_CH_ZERO + {4'd0, fg_ones};
        o_slots.data[3] = icte_pkg::C_CH_COMMA;
        o_slots.data[4] = icte_pkg::C_CH_ZERO + {4'd0, bg_tens};
        o_slots.data[5] = icte_pkg::C_CH_ZERO + {4'd0, bg_ones};
        o_slots.data[6] = ch_byte;

        o_slots.en[0] = new_fg || new_bg;
        o_slots.en[1] = new_fg && (fg_two || (fg_tens != 4'd0));
        o_slots.en[2] = new_fg;
        o_slots.en[3] = new_bg;
        o_slots.en[4] = new_bg && (i_next_digit || (bg_tens != 4'd0));
        o_slots.en[5] = new_bg;
        o_slots.en[6] = 1'b1;
    end

endmodule

`default_nettype wire
